/* hw/rtl/section_rva_to_file_offset_defines.svh */
// ----------------------------------------------------------------------------
// Section RVA translation - assertion macros
// Shared concurrent assertion shorthands, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SECTION_RVA_TO_FILE_OFFSET_DEFINES_SVH
`define SECTION_RVA_TO_FILE_OFFSET_DEFINES_SVH

// same-cycle implication; the consequent may carry a constant delay
`define SRTFO_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("assertion failed");

// next-cycle implication
`define SRTFO_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/srtfo_pkg.sv */
// ----------------------------------------------------------------------------
// Section RVA translation - package
// Table size, field widths, opcodes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package srtfo_pkg;

   localparam int MaxSections = 16;
   localparam int IndexWidth  = 4;
   localparam int CountWidth  = 5;
   localparam int DataWidth   = 32;
   localparam int CsrIdxWidth = 4;

   typedef enum logic {
      OP_WRITE     = 1'b0,
      OP_TRANSLATE = 1'b1
   } op_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ENTRY_COUNT = 4'd0,
      CSR_IMAGE_BASE  = 4'd1
   } csr_index_type;

endpackage

`default_nettype wire

/* hw/rtl/section_rva_to_file_offset.sv */
// Translates a relative virtual address to a file offset through a section table.
// A result passes through the input register, the compare, the priority select and
// an add into the output register before the result strobe rises.
// Throughput: one transaction per cycle; busy stays low, results cannot be held off.
// Reset clears the pipeline valid bits and both registers; the table is not cleared.
// ----------------------------------------------------------------------------
// Section RVA translation - top level
// Loads section entries and looks up addresses in a four-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "section_rva_to_file_offset_defines.svh"

module section_rva_to_file_offset (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_op,
   input  wire logic [srtfo_pkg::IndexWidth-1:0]     req_entry_index,
   input  wire logic [srtfo_pkg::DataWidth-1:0]      req_entry_start,
   input  wire logic [srtfo_pkg::DataWidth-1:0]      req_entry_raw_size,
   input  wire logic [srtfo_pkg::DataWidth-1:0]      req_entry_raw_offset,
   input  wire logic [srtfo_pkg::DataWidth-1:0]      req_rel_address,
   // response
   output logic                                      rsp_strobe,
   output logic                                      rsp_found,
   output logic [srtfo_pkg::DataWidth-1:0]           rsp_file_offset,
   output logic [srtfo_pkg::DataWidth-1:0]           rsp_virtual_address,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [srtfo_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [srtfo_pkg::DataWidth-1:0]      csr_data
);
   import srtfo_pkg::*;

   logic                    accept;
   logic                    tbl_we;

   // configuration registers
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [DataWidth-1:0]    base_ff, base_in;

   // section table: start, inclusive end, offset bias
   logic [DataWidth-1:0]    start_ff [MaxSections];
   logic [DataWidth-1:0]    end_ff   [MaxSections];
   logic [DataWidth-1:0]    bias_ff  [MaxSections];
   logic [DataWidth-1:0]    start_in, end_in, bias_in;

   // delayed bias write
   logic                    bw_valid_ff, bw_valid_in;
   logic [IndexWidth-1:0]   bw_slot_ff, bw_slot_in;
   logic [DataWidth-1:0]    bw_bias_ff, bw_bias_in;

   // stage A: accepted translate
   logic                    a_valid_ff, a_valid_in;
   logic [DataWidth-1:0]    a_addr_ff, a_addr_in;

   // stage B: per-entry hit vector
   logic                    b_valid_ff, b_valid_in;
   logic [DataWidth-1:0]    b_addr_ff, b_addr_in;
   logic [MaxSections-1:0]  b_hit_ff, b_hit_in;

   // stage C: selected entry
   logic                    c_valid_ff, c_valid_in;
   logic [DataWidth-1:0]    c_addr_ff, c_addr_in;
   logic                    c_found_ff, c_found_in;
   logic [DataWidth-1:0]    c_bias_ff, c_bias_in;
   logic [MaxSections-1:0]  c_sel_ff, c_sel_in;

   // output register
   logic                    out_strobe_ff, out_strobe_in;
   logic                    out_found_ff, out_found_in;
   logic [DataWidth-1:0]    out_offset_ff, out_offset_in;
   logic [DataWidth-1:0]    out_va_ff, out_va_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // ---------------- configuration ----------------
   always_comb begin
      count_in = count_ff;
      base_in  = base_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: count_in = csr_data[CountWidth-1:0];
            CSR_IMAGE_BASE:  base_in  = csr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         base_ff  <= '0;
      end else begin
         count_ff <= count_in;
         base_ff  <= base_in;
      end
   end

   // ---------------- table write ----------------
   // store the inclusive end and the offset bias so the compare needs no add and the offset needs a single add
   assign start_in = req_entry_start;
   assign end_in   = req_entry_start + req_entry_raw_size;
   assign bias_in  = req_entry_raw_offset - req_entry_start;
   assign tbl_we   = accept && (op_type'(req_op) == OP_WRITE)
                     && ({1'b0, req_entry_index} < (IndexWidth + 1)'(MaxSections));

   // stage C reads the bias in the cycle after stage B reads the bounds, so
   // the bias write passes through the bw register to keep both views in step
   assign bw_valid_in = tbl_we;
   assign bw_slot_in  = req_entry_index;
   assign bw_bias_in  = bias_in;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         start_ff[req_entry_index] <= start_in;
         end_ff[req_entry_index]   <= end_in;
      end
      if (bw_valid_ff) begin
         bias_ff[bw_slot_ff] <= bw_bias_ff;
      end
   end

   // ---------------- stage A ----------------
   assign a_valid_in = accept && (op_type'(req_op) == OP_TRANSLATE);
   assign a_addr_in  = req_rel_address;

   // ---------------- stage B: compare all entries ----------------
   always_comb begin
      for (int i = 0; i < MaxSections; i++) begin
         b_hit_in[i] = (CountWidth'(i) < count_ff)
                       && (a_addr_ff != '0)
                       && (start_ff[i] <= a_addr_ff)
                       && (a_addr_ff <= end_ff[i]);
      end
   end
   assign b_valid_in = a_valid_ff;
   assign b_addr_in  = a_addr_ff;

   // ---------------- stage C: lowest index wins ----------------
   always_comb begin
      c_sel_in  = b_hit_ff & (~b_hit_ff + MaxSections'(1));
      c_bias_in = '0;
      for (int i = 0; i < MaxSections; i++) begin
         c_bias_in = c_bias_in | ({DataWidth{c_sel_in[i]}} & bias_ff[i]);
      end
   end
   assign c_found_in = |b_hit_ff;
   assign c_valid_in = b_valid_ff;
   assign c_addr_in  = b_addr_ff;

   // ---------------- output stage ----------------
   assign out_strobe_in = c_valid_ff;
   assign out_found_in  = c_found_ff;
   assign out_offset_in = c_found_ff ? (c_addr_ff + c_bias_ff) : '0;
   assign out_va_in     = base_ff + c_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_valid_ff   <= 1'b0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         bw_valid_ff   <= bw_valid_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         c_valid_ff    <= c_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      bw_slot_ff    <= bw_slot_in;
      bw_bias_ff    <= bw_bias_in;
      a_addr_ff     <= a_addr_in;
      b_addr_ff     <= b_addr_in;
      b_hit_ff      <= b_hit_in;
      c_addr_ff     <= c_addr_in;
      c_found_ff    <= c_found_in;
      c_bias_ff     <= c_bias_in;
      c_sel_ff      <= c_sel_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
      out_va_ff     <= out_va_in;
   end

   assign rsp_strobe          = out_strobe_ff;
   assign rsp_found           = out_found_ff;
   assign rsp_file_offset     = out_offset_ff;
   assign rsp_virtual_address = out_va_ff;

   // ---------------- assertions ----------------
   `SRTFO_ASSERT_IMP(a_translate_gives_result,
      start && !busy && (op_type'(req_op) == OP_TRANSLATE), ##4 rsp_strobe)
   `SRTFO_ASSERT_IMP(a_write_gives_no_result,
      start && !busy && (op_type'(req_op) == OP_WRITE), ##4 !rsp_strobe)
   `SRTFO_ASSERT_IMP(a_select_onehot, c_valid_ff,
      ($onehot0(c_sel_ff) && ((c_sel_ff != '0) == c_found_ff)))
   `SRTFO_ASSERT_IMP(a_miss_zero_offset, rsp_strobe && !rsp_found,
      (rsp_file_offset == '0))

endmodule

`default_nettype wire

/* test/section_rva_to_file_offset_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Section RVA translation - testbench
// Loads section entries and looks up addresses with random pacing. A mirror of
// the section table and registers predicts every lookup; each result strobe is
// compared field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module section_rva_to_file_offset_test;
   import srtfo_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 8;
   localparam int MaxReported   = 10;

   typedef struct {
      op_type                 op;
      logic [IndexWidth-1:0]  slot;
      logic [DataWidth-1:0]   entry_start;
      logic [DataWidth-1:0]   raw_size;
      logic [DataWidth-1:0]   raw_offset;
      logic [DataWidth-1:0]   rel_address;
   } section_request_type;

   typedef struct {
      logic                   found;
      logic [DataWidth-1:0]   file_offset;
      logic [DataWidth-1:0]   virtual_address;
   } translation_type;

   class translation_tracker_type;
      logic [DataWidth-1:0]   starts      [MaxSections];
      logic [DataWidth-1:0]   raw_sizes   [MaxSections];
      logic [DataWidth-1:0]   raw_offsets [MaxSections];
      logic [CountWidth-1:0]  entry_count;
      logic [DataWidth-1:0]   image_base;
      translation_type        pending_translations[$];
      int                     mismatch_count;

      function new();
         entry_count    = '0;
         image_base     = '0;
         mismatch_count = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [DataWidth-1:0] data);
         case (idx)
            CSR_ENTRY_COUNT: entry_count = data[CountWidth-1:0];
            CSR_IMAGE_BASE:  image_base = data;
            default: ;
         endcase
      endfunction

      // counts beyond the table size saturate
      function int searched_sections();
         return (entry_count > MaxSections) ? MaxSections : int'(entry_count);
      endfunction

      function translation_type translate(logic [DataWidth-1:0] addr);
         translation_type      t;
         logic [DataWidth-1:0] upper;
         int                   limit;
         limit = searched_sections();
         t.found = 1'b0;
         t.file_offset = '0;
         t.virtual_address = image_base + addr;
         if (addr != '0) begin
            for (int i = 0; i < limit; i++) begin
               upper = starts[i] + raw_sizes[i];
               if (!t.found && addr >= starts[i] && addr <= upper) begin
                  t.found = 1'b1;
                  t.file_offset = addr - starts[i] + raw_offsets[i];
               end
            end
         end
         return t;
      endfunction

      function void note_request(section_request_type r);
         if (r.op == OP_WRITE) begin
            starts[r.slot]      = r.entry_start;
            raw_sizes[r.slot]   = r.raw_size;
            raw_offsets[r.slot] = r.raw_offset;
         end else begin
            pending_translations.push_back(translate(r.rel_address));
         end
      endfunction

      function void note_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= MaxReported) $display("mismatch: %s", what);
      endfunction

      function void check_translation(translation_type got);
         translation_type want;
         if (pending_translations.size() == 0) begin
            note_mismatch($sformatf("unexpected result found=%b offset=%h va=%h",
                                    got.found, got.file_offset, got.virtual_address));
            return;
         end
         want = pending_translations.pop_front();
         if (got.found !== want.found)
            note_mismatch($sformatf("found expected %b, got %b", want.found, got.found));
         if (got.file_offset !== want.file_offset)
            note_mismatch($sformatf("file_offset expected %h, got %h",
                                    want.file_offset, got.file_offset));
         if (got.virtual_address !== want.virtual_address)
            note_mismatch($sformatf("virtual_address expected %h, got %h",
                                    want.virtual_address, got.virtual_address));
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_op = 1'b0;
   logic [IndexWidth-1:0]        req_entry_index = '0;
   logic [DataWidth-1:0]         req_entry_start = '0;
   logic [DataWidth-1:0]         req_entry_raw_size = '0;
   logic [DataWidth-1:0]         req_entry_raw_offset = '0;
   logic [DataWidth-1:0]         req_rel_address = '0;
   logic                         rsp_strobe;
   logic                         rsp_found;
   logic [DataWidth-1:0]         rsp_file_offset;
   logic [DataWidth-1:0]         rsp_virtual_address;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIdxWidth-1:0]       csr_index = '0;
   logic [DataWidth-1:0]         csr_data = '0;

   translation_tracker_type      tracker = new();
   int                           quiet_cycles = 0;

   section_rva_to_file_offset dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_entry_index      (req_entry_index),
      .req_entry_start      (req_entry_start),
      .req_entry_raw_size   (req_entry_raw_size),
      .req_entry_raw_offset (req_entry_raw_offset),
      .req_rel_address      (req_rel_address),
      .rsp_strobe           (rsp_strobe),
      .rsp_found            (rsp_found),
      .rsp_file_offset      (rsp_file_offset),
      .rsp_virtual_address  (rsp_virtual_address),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_translation(translation_type'{rsp_found, rsp_file_offset,
                                                     rsp_virtual_address});
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic section_request_type load_of(logic [IndexWidth-1:0] slot,
                                                   logic [DataWidth-1:0] lo,
                                                   logic [DataWidth-1:0] size,
                                                   logic [DataWidth-1:0] offset);
      section_request_type r;
      r.op          = OP_WRITE;
      r.slot        = slot;
      r.entry_start = lo;
      r.raw_size    = size;
      r.raw_offset  = offset;
      r.rel_address = $urandom();
      return r;
   endfunction

   function automatic section_request_type lookup_of(logic [DataWidth-1:0] addr);
      section_request_type r;
      r.op          = OP_TRANSLATE;
      r.slot        = IndexWidth'($urandom());
      r.entry_start = $urandom();
      r.raw_size    = $urandom();
      r.raw_offset  = $urandom();
      r.rel_address = addr;
      return r;
   endfunction

   // cluster most sections low so that they overlap and priority matters
   function automatic section_request_type random_load(logic [IndexWidth-1:0] slot);
      logic [DataWidth-1:0] lo;
      logic [DataWidth-1:0] size;
      case ($urandom_range(9))
         0:       lo = $urandom();
         1:       lo = 32'hFFFF_0000 + $urandom_range(32'hFFFF);
         default: lo = $urandom_range(32'h2_0000);
      endcase
      case ($urandom_range(9))
         0:       size = '0;
         1:       size = 32'hFFFF_FFFF;
         2:       size = $urandom();
         default: size = $urandom_range(32'h4000);
      endcase
      return load_of(slot, lo, size, $urandom());
   endfunction

   function automatic section_request_type random_lookup();
      logic [DataWidth-1:0] lo;
      logic [DataWidth-1:0] size;
      int                   limit;
      int                   slot;
      limit = tracker.searched_sections();
      slot  = (limit > 0) ? $urandom_range(limit - 1) : $urandom_range(MaxSections - 1);
      lo    = tracker.starts[slot];
      size  = tracker.raw_sizes[slot];
      case ($urandom_range(19))
         0:       return lookup_of('0);
         1:       return lookup_of(lo - 1);
         2:       return lookup_of(lo + size + 1);
         3:       return lookup_of(lo + size);
         4:       return lookup_of(lo);
         5, 6, 7: return lookup_of($urandom());
         default: return lookup_of(lo + $urandom_range(size));
      endcase
   endfunction

   task automatic send_request(section_request_type r, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                <= 1'b1;
      req_op               <= r.op;
      req_entry_index      <= r.slot;
      req_entry_start      <= r.entry_start;
      req_entry_raw_size   <= r.raw_size;
      req_entry_raw_offset <= r.raw_offset;
      req_rel_address      <= r.rel_address;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(r);
   endtask

   task automatic wait_for_drain();
      while (tracker.pending_translations.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // write both registers back to back once the pipeline is empty
   task automatic configure(logic [CountWidth-1:0] count, logic [DataWidth-1:0] base);
      logic [DataWidth-1:0] count_data;
      count_data = $urandom();
      count_data[CountWidth-1:0] = count;
      start <= 1'b0;
      wait_for_drain();
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? CSR_ENTRY_COUNT : CSR_IMAGE_BASE;
         csr_data  <= (k == 0) ? count_data : base;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.write_register((k == 0) ? CSR_ENTRY_COUNT : CSR_IMAGE_BASE,
                                (k == 0) ? count_data : base);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CountWidth-1:0] count;
      logic [DataWidth-1:0]  base;
      int                    idle_pct;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty search: nothing matches, virtual address wraps
      configure('0, 32'hFFFF_FFFF);
      send_request(lookup_of(32'h1), 32);
      send_request(lookup_of(32'hFFFF_FFFF), 32);

      // fill every slot before anything is searched
      send_request(load_of(4'd0, 32'h1000, 32'h200, 32'h400), 32);
      send_request(load_of(4'd1, 32'h1100, 32'h100, 32'h8000), 32);
      send_request(load_of(4'd2, 32'h0, 32'h10, 32'h20), 32);
      send_request(load_of(4'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF), 32);
      send_request(load_of(4'd4, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0), 32);
      send_request(load_of(4'd5, 32'h2000, 32'h1000, 32'hFFFF_E000), 32);
      send_request(load_of(4'd6, 32'h5000, 32'h100, 32'hFFFF_FFF0), 32);
      for (int s = 7; s < MaxSections; s++)
         send_request(random_load(IndexWidth'(s)), 32);

      configure(CountWidth'(MaxSections), '0);
      send_request(lookup_of(32'h0), 32);
      send_request(lookup_of(32'h1000), 32);
      send_request(lookup_of(32'h1200), 32);
      send_request(lookup_of(32'h1150), 32);
      send_request(lookup_of(32'h1201), 32);
      send_request(lookup_of(32'h5), 32);
      send_request(lookup_of(32'hFFFF_FFFF), 32);
      send_request(lookup_of(32'h2FFF), 32);
      send_request(lookup_of(32'h5080), 32);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: begin count = 5'd31; base = 32'hFFFF_FFFF; end
            1: begin count = 5'd0;  base = 32'h0;         end
            2: begin count = 5'd1;  base = $urandom();    end
            3: begin count = 5'd16; base = 32'h8000_0000; end
            default: begin count = CountWidth'($urandom_range(31)); base = $urandom(); end
         endcase
         idle_pct = (p == 4) ? 0 : 32;
         configure(count, base);
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(3) == 0)
               send_request(random_load(IndexWidth'($urandom_range(MaxSections - 1))),
                            idle_pct);
            else
               send_request(random_lookup(), idle_pct);
         end
      end

      start <= 1'b0;
      wait_for_drain();
      if (tracker.mismatch_count == 0 && tracker.pending_translations.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/srtfo_pkg.sv
hw/rtl/section_rva_to_file_offset.sv
test/section_rva_to_file_offset_test.sv
